// ===== rtl/mftp_pkg.sv =====
package mftp_pkg;

  localparam logic [7:0] StatusMeta    = 8'hFF;
  localparam logic [7:0] StatusSysex   = 8'hF0;
  localparam logic [7:0] StatusEscape  = 8'hF7;
  localparam logic [7:0] StatusSystem  = 8'hF0;
  localparam logic [7:0] MetaEndTrack  = 8'h2F;
  localparam logic [3:0] NoteOnNibble  = 4'h9;
  localparam logic [3:0] NoteOffNibble = 4'h8;
  localparam logic [6:0] OffVelocity   = 7'h40;
  localparam logic [1:0] MaxLenReset   = 2'd3;

  typedef enum logic [1:0] {
    KindEvent   = 2'd0,
    KindSkipped = 2'd1,
    KindEnd     = 2'd2,
    KindCorrupt = 2'd3
  } kind_e;

  typedef enum logic [6:0] {
    PhDelta    = 7'b0000001,
    PhStatus   = 7'b0000010,
    PhData     = 7'b0000100,
    PhMetaType = 7'b0001000,
    PhSize     = 7'b0010000,
    PhSkip     = 7'b0100000,
    PhHalt     = 7'b1000000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  status;
    logic [6:0]  first;
    logic [6:0]  second;
    logic [1:0]  length;
    logic [31:0] delta;
  } result_t;

  // Message length in bytes, status byte included.
  function automatic logic [1:0] length_of(logic [7:0] st);
    logic [1:0] len;
    if (st < 8'hC0) begin
      len = 2'd3;
    end else if (st < 8'hE0) begin
      len = 2'd2;
    end else if (st < 8'hF0) begin
      len = 2'd3;
    end else if (st == 8'hF1 || st == 8'hF3) begin
      len = 2'd2;
    end else if (st == 8'hF2) begin
      len = 2'd3;
    end else begin
      len = 2'd1;
    end
    return len;
  endfunction

endpackage

// ===== rtl/mftp_parser.sv =====
module mftp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  input  logic [1:0]       max_len_i,
  output logic             res_valid_o,
  output mftp_pkg::result_t res_o
);
  import mftp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] delta_q, delta_d;
  logic [7:0]  run_status_q, run_status_d;
  logic [1:0]  run_len_q, run_len_d;
  logic [7:0]  cur_status_q, cur_status_d;
  logic [6:0]  data_q, data_d;
  logic        data_cnt_q, data_cnt_d;
  logic        meta_eot_q, meta_eot_d;
  logic [31:0] skip_q, skip_d;

  logic [6:0]  low;
  logic        begin_ev;
  logic        pre;
  logic [6:0]  pre_d1;
  logic [7:0]  st_b;
  logic [1:0]  len_b;
  logic [1:0]  need;
  logic [31:0] size_next;
  logic [31:0] skip_dec;
  logic [6:0]  fin_d2;
  logic        rewrite;

  assign low       = byte_i[6:0];
  assign size_next = {skip_q[24:0], low};
  assign skip_dec  = skip_q - 32'd1;
  assign need      = len_b - 2'd1 - {1'b0, pre};
  assign fin_d2    = low;
  assign rewrite   = (run_len_q == 2'd3) && (cur_status_q[7:4] == NoteOnNibble) &&
                     (fin_d2 == 7'd0);

  always_comb begin
    phase_d      = phase_q;
    delta_d      = delta_q;
    run_status_d = run_status_q;
    run_len_d    = run_len_q;
    cur_status_d = cur_status_q;
    data_d       = data_q;
    data_cnt_d   = data_cnt_q;
    meta_eot_d   = meta_eot_q;
    skip_d       = skip_q;
    begin_ev     = 1'b0;
    pre          = 1'b0;
    pre_d1       = '0;
    st_b         = byte_i;
    len_b        = length_of(byte_i);
    res_valid_o  = 1'b0;
    res_o        = '0;
    res_o.delta  = delta_q;

    if (accept_i) begin
      unique case (phase_q)
        PhDelta: begin
          delta_d = {delta_q[24:0], low};
          if (!byte_i[7]) phase_d = PhStatus;
        end
        PhStatus: begin
          if (!byte_i[7]) begin
            if (run_status_q == 8'd0) begin
              res_valid_o = 1'b1;
              res_o.kind  = KindCorrupt;
            end else begin
              st_b     = run_status_q;
              len_b    = length_of(run_status_q);
              begin_ev = 1'b1;
              pre      = 1'b1;
              pre_d1   = low;
            end
          end else if (byte_i < StatusSystem) begin
            run_status_d = byte_i;
            begin_ev     = 1'b1;
          end else begin
            run_status_d = 8'd0;
            cur_status_d = byte_i;
            if (byte_i == StatusMeta) begin
              phase_d = PhMetaType;
            end else if (byte_i == StatusSysex || byte_i == StatusEscape) begin
              skip_d  = '0;
              phase_d = PhSize;
            end else begin
              begin_ev = 1'b1;
            end
          end
          if (begin_ev) begin
            cur_status_d = st_b;
            run_len_d    = len_b;
            if (len_b > max_len_i) begin
              if (need == 2'd0) begin
                res_valid_o  = 1'b1;
                res_o.kind   = KindSkipped;
                res_o.status = st_b;
              end else begin
                skip_d  = {30'd0, need};
                phase_d = PhSkip;
              end
            end else if (need == 2'd0) begin
              res_valid_o  = 1'b1;
              res_o.kind   = KindEvent;
              res_o.status = st_b;
              res_o.first  = pre_d1;
              res_o.length = len_b;
            end else begin
              data_d     = pre_d1;
              data_cnt_d = pre;
              phase_d    = PhData;
            end
          end
        end
        PhData: begin
          if (!data_cnt_q && run_len_q == 2'd3) begin
            data_d     = low;
            data_cnt_d = 1'b1;
          end else begin
            res_valid_o  = 1'b1;
            res_o.kind   = KindEvent;
            res_o.length = run_len_q;
            res_o.status = cur_status_q;
            if (run_len_q == 2'd2) begin
              res_o.first = low;
            end else begin
              res_o.first  = data_q;
              res_o.second = fin_d2;
              if (rewrite) begin
                res_o.status = {NoteOffNibble, cur_status_q[3:0]};
                res_o.second = OffVelocity;
              end
            end
          end
        end
        PhMetaType: begin
          meta_eot_d = (byte_i == MetaEndTrack);
          skip_d     = '0;
          phase_d    = PhSize;
        end
        PhSize: begin
          skip_d = size_next;
          if (!byte_i[7]) begin
            if (cur_status_q == StatusMeta && meta_eot_q) begin
              res_valid_o  = 1'b1;
              res_o.kind   = KindEnd;
              res_o.status = StatusMeta;
            end else if (size_next == 32'd0) begin
              res_valid_o  = 1'b1;
              res_o.kind   = KindSkipped;
              res_o.status = cur_status_q;
            end else begin
              phase_d = PhSkip;
            end
          end
        end
        PhSkip: begin
          skip_d = skip_dec;
          if (skip_dec == 32'd0) begin
            res_valid_o  = 1'b1;
            res_o.kind   = KindSkipped;
            res_o.status = cur_status_q;
          end
        end
        PhHalt: begin
        end
        default: begin
        end
      endcase

      if (res_valid_o) begin
        delta_d = '0;
        phase_d = (res_o.kind == KindEnd || res_o.kind == KindCorrupt) ? PhHalt : PhDelta;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhDelta;
      delta_q      <= '0;
      run_status_q <= '0;
      run_len_q    <= '0;
      cur_status_q <= '0;
      data_q       <= '0;
      data_cnt_q   <= 1'b0;
      meta_eot_q   <= 1'b0;
      skip_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      delta_q      <= delta_d;
      run_status_q <= run_status_d;
      run_len_q    <= run_len_d;
      cur_status_q <= cur_status_d;
      data_q       <= data_d;
      data_cnt_q   <= data_cnt_d;
      meta_eot_q   <= meta_eot_d;
      skip_q       <= skip_d;
    end
  end

  a_res_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> accept_i)
    else $error("result without accepted byte");

  a_halt_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KindEnd || res_o.kind == KindCorrupt)
    |=> phase_q == PhHalt)
    else $error("parser did not halt");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHalt |-> !res_valid_o)
    else $error("result while halted");

  a_event_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KindEvent
    |-> res_o.length != 2'd0 && res_o.length <= max_len_i)
    else $error("event length out of range");

  a_other_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind != KindEvent
    |-> res_o.length == 2'd0 && res_o.first == 7'd0 && res_o.second == 7'd0)
    else $error("non-event result carries data");

endmodule

// ===== rtl/midi_file_track_event_parser_unit.sv =====
// Channel   Direction  Handshake                Payload
// track     in         in_valid_i / in_ready_o  track_byte_i
// result    out        out_valid_o / out_ready_i
//                      result_kind_o, status_byte_o, first_data_o,
//                      second_data_o, event_length_o, delta_ticks_o
// config    in         cfg_we_i (no wait)       cfg_wdata_i
//
// One byte per cycle unless stalled; a result is registered the cycle after
// its last byte. Rate is set by the single parser state update per byte.
// Reset: parser in delta time phase, its state zero, limit 3, no result.
// A stalled result holds the register; a byte is still taken in the cycle
// the result is taken, so input ready follows out_ready_i while full.
module midi_file_track_event_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  track_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  status_byte_o,
  output logic [6:0]  first_data_o,
  output logic [6:0]  second_data_o,
  output logic [1:0]  event_length_o,
  output logic [31:0] delta_ticks_o
);
  import mftp_pkg::*;

  logic [1:0] max_len_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q, out_d;
  logic       accept;
  logic       res_valid;
  result_t    res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  mftp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (track_byte_i),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MaxLenReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.kind;
  assign status_byte_o  = out_q.status;
  assign first_data_o   = out_q.first;
  assign second_data_o  = out_q.second;
  assign event_length_o = out_q.length;
  assign delta_ticks_o  = out_q.delta;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_valid_q || out_ready_i)
    else $error("pending result overwritten");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q)
    else $error("result not loaded");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !res_valid |=> !out_valid_q)
    else $error("taken result not cleared");

endmodule

// ===== sim/track_event_checker.sv =====
module track_event_checker
  import mftp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  track_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  result_kind_i,
  input  logic [7:0]  status_byte_i,
  input  logic [6:0]  first_data_i,
  input  logic [6:0]  second_data_i,
  input  logic [1:0]  event_length_i,
  input  logic [31:0] delta_ticks_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  logic [1:0]  limit_q;
  phase_e      phase_q;
  logic [31:0] ticks_acc;
  logic [7:0]  running_st;
  logic [1:0]  running_len;
  logic [7:0]  event_st;
  logic [6:0]  held_data;
  logic        held_cnt;
  logic [7:0]  meta_type;
  logic [31:0] skip_left;
  result_t     staged;
  result_t     got;
  result_t     want;
  result_t     expected_events [$];

  function automatic logic [1:0] message_bytes(logic [7:0] st);
    if (st < 8'hC0) return 2'd3;
    if (st < 8'hE0) return 2'd2;
    if (st < StatusSystem) return 2'd3;
    if (st == 8'hF1 || st == 8'hF3) return 2'd2;
    if (st == 8'hF2) return 2'd3;
    return 2'd1;
  endfunction

  function automatic bit report(kind_e kind, logic [7:0] st, logic [6:0] d1,
                                logic [6:0] d2, logic [1:0] len);
    staged.kind   = kind;
    staged.status = st;
    staged.first  = d1;
    staged.second = d2;
    staged.length = len;
    staged.delta  = ticks_acc;
    ticks_acc = '0;
    phase_q = (kind == KindEnd || kind == KindCorrupt) ? PhHalt : PhDelta;
    return 1'b1;
  endfunction

  function automatic bit complete_event(logic [6:0] d1, logic [6:0] d2);
    logic [7:0] st;
    logic [6:0] vel;
    st  = event_st;
    vel = d2;
    if (running_len == 2'd3 && st[7:4] == NoteOnNibble && vel == '0) begin
      st  = {NoteOffNibble, st[3:0]};
      vel = OffVelocity;
    end
    return report(KindEvent, st, d1, vel, running_len);
  endfunction

  // pre: a data byte already came in as running status
  function automatic bit open_event(logic pre, logic [6:0] d1);
    logic [1:0] need;
    need = running_len - 2'd1 - {1'b0, pre};
    if (running_len > limit_q) begin
      if (need == '0) return report(KindSkipped, event_st, '0, '0, '0);
      skip_left = {30'd0, need};
      phase_q = PhSkip;
      return 1'b0;
    end
    if (need == '0) return complete_event(d1, '0);
    held_data = d1;
    held_cnt  = pre;
    phase_q   = PhData;
    return 1'b0;
  endfunction

  function automatic bit parse_track_byte(logic [7:0] b);
    logic [6:0] low;
    low = b[6:0];
    case (phase_q)
      PhDelta: begin
        ticks_acc = (ticks_acc << 7) + {25'd0, low};
        if (!b[7]) phase_q = PhStatus;
        return 1'b0;
      end
      PhStatus: begin
        if (!b[7]) begin
          if (running_st == '0) return report(KindCorrupt, '0, '0, '0, '0);
          event_st    = running_st;
          running_len = message_bytes(running_st);
          return open_event(1'b1, low);
        end
        event_st = b;
        if (b < StatusSystem) begin
          running_st  = b;
          running_len = message_bytes(b);
          return open_event(1'b0, '0);
        end
        running_st = '0;
        if (b == StatusMeta) begin
          phase_q = PhMetaType;
          return 1'b0;
        end
        if (b == StatusSysex || b == StatusEscape) begin
          skip_left = '0;
          phase_q   = PhSize;
          return 1'b0;
        end
        running_len = message_bytes(b);
        return open_event(1'b0, '0);
      end
      PhData: begin
        if (!held_cnt && running_len == 2'd3) begin
          held_data = low;
          held_cnt  = 1'b1;
          return 1'b0;
        end
        if (running_len == 2'd2) return complete_event(low, '0);
        return complete_event(held_data, low);
      end
      PhMetaType: begin
        meta_type = b;
        skip_left = '0;
        phase_q   = PhSize;
        return 1'b0;
      end
      PhSize: begin
        skip_left = (skip_left << 7) + {25'd0, low};
        if (b[7]) return 1'b0;
        if (event_st == StatusMeta && meta_type == MetaEndTrack) begin
          return report(KindEnd, StatusMeta, '0, '0, '0);
        end
        if (skip_left == '0) return report(KindSkipped, event_st, '0, '0, '0);
        phase_q = PhSkip;
        return 1'b0;
      end
      PhSkip: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == '0) return report(KindSkipped, event_st, '0, '0, '0);
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic note_failure(string what);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%s: expected kind=%0d status=%h d1=%h d2=%h len=%0d delta=%h",
               what, want.kind, want.status, want.first, want.second, want.length,
               want.delta);
      $display("    got      kind=%0d status=%h d1=%h d2=%h len=%0d delta=%h",
               got.kind, got.status, got.first, got.second, got.length, got.delta);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      = MaxLenReset;
      phase_q      = PhDelta;
      ticks_acc    = '0;
      running_st   = '0;
      running_len  = '0;
      event_st     = '0;
      held_data    = '0;
      held_cnt     = 1'b0;
      meta_type    = '0;
      skip_left    = '0;
      expected_events.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.kind   = kind_e'(result_kind_i);
        got.status = status_byte_i;
        got.first  = first_data_i;
        got.second = second_data_i;
        got.length = event_length_i;
        got.delta  = delta_ticks_i;
        checked_o++;
        if (expected_events.size() == 0) begin
          want = '0;
          note_failure("result with nothing pending");
        end else begin
          want = expected_events.pop_front();
          if (got.kind !== want.kind || got.status !== want.status ||
              got.first !== want.first || got.second !== want.second ||
              got.length !== want.length || got.delta !== want.delta) begin
            note_failure("result mismatch");
          end
        end
      end
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (parse_track_byte(track_byte_i)) expected_events.push_back(staged);
      end
      pending_o = expected_events.size();
    end
  end

endmodule

// ===== sim/tb_midi_file_track_event_parser_unit.sv =====
module tb_midi_file_track_event_parser_unit;
  import mftp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  track_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  status_byte_o;
  logic [6:0]  first_data_o;
  logic [6:0]  second_data_o;
  logic [1:0]  event_length_o;
  logic [31:0] delta_ticks_o;

  int         mismatches;
  int         pending;
  int         results_seen;
  int         bytes_sent;
  int         tx_calm;
  int         rx_calm;
  bit         running_ok;
  logic [7:0] last_running;

  midi_file_track_event_parser_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .track_byte_i   (track_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .status_byte_o  (status_byte_o),
    .first_data_o   (first_data_o),
    .second_data_o  (second_data_o),
    .event_length_o (event_length_o),
    .delta_ticks_o  (delta_ticks_o)
  );

  track_event_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .track_byte_i   (track_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_i  (result_kind_o),
    .status_byte_i  (status_byte_o),
    .first_data_i   (first_data_o),
    .second_data_i  (second_data_o),
    .event_length_i (event_length_o),
    .delta_ticks_i  (delta_ticks_o),
    .fail_count_o   (mismatches),
    .pending_o      (pending),
    .checked_o      (results_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // zero-gap stretches now and then
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [7:0] loose_data();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] random_channel_status();
    if ($urandom_range(0, 2) == 0) return {NoteOnNibble, 4'($urandom_range(0, 15))};
    return 8'($urandom_range(8'h80, 8'hEF));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    track_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_vlq(input logic [31:0] v, input int pad);
    logic [6:0]  grp [$];
    logic [31:0] r;
    r = v;
    grp.push_front(r[6:0]);
    r = r >> 7;
    while (r != '0) begin
      grp.push_front(r[6:0]);
      r = r >> 7;
    end
    repeat (pad) send_byte(8'h80);
    for (int i = 0; i < grp.size(); i++) send_byte({i != grp.size() - 1, grp[i]});
  endtask

  task automatic send_random_delta();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
    for (int i = 1; i < n; i++) send_byte(8'($urandom_range(128, 255)));
    send_byte(8'($urandom_range(0, 127)));
  endtask

  task automatic send_channel(input logic [7:0] st, input bit use_running);
    int n;
    n = int'(length_of(st)) - 1;
    send_random_delta();
    if (!use_running) send_byte(st);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && use_running) begin
        send_byte(8'($urandom_range(0, 127)));
      end else if (i == n - 1 && st[7:4] == NoteOnNibble && $urandom_range(0, 2) == 0) begin
        send_byte($urandom_range(0, 1) ? 8'h80 : 8'h00);
      end else begin
        send_byte(loose_data());
      end
    end
    running_ok   = 1'b1;
    last_running = st;
  endtask

  task automatic send_system(input logic [7:0] st);
    send_random_delta();
    send_byte(st);
    repeat (int'(length_of(st)) - 1) send_byte(loose_data());
    running_ok = 1'b0;
  endtask

  task automatic send_blob(input logic [7:0] st, input logic [7:0] kind, input int size,
                           input int pad);
    send_random_delta();
    send_byte(st);
    if (st == StatusMeta) send_byte(kind);
    send_vlq(size, pad);
    repeat (size) send_byte(8'($urandom));
    running_ok = 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_event();
    int         pick;
    int         size;
    int         pad;
    logic [7:0] st;
    pick = $urandom_range(0, 99);
    size = ($urandom_range(0, 29) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 6);
    pad  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    if (pick < 30 && running_ok) begin
      send_channel(last_running, 1'b1);
    end else if (pick < 70) begin
      send_channel(random_channel_status(), 1'b0);
    end else if (pick < 80) begin
      st = 8'($urandom_range(8'hF1, 8'hFE));
      if (st == StatusEscape) st = 8'hF6;
      send_system(st);
    end else if (pick < 88) begin
      send_blob($urandom_range(0, 1) ? StatusSysex : StatusEscape, 8'h00, size, pad);
    end else begin
      st = 8'($urandom);
      if (st == MetaEndTrack) st = 8'h51;
      send_blob(StatusMeta, st, size, pad);
    end
  endtask

  task automatic directed_part();
    send_vlq(0, 0);
    send_byte(8'h90); send_byte(8'h3C); send_byte(8'h64);
    // delta that overflows 32 bits, then running note-on with zero velocity
    repeat (4) send_byte(8'hFF);
    send_byte(8'h7F); send_byte(8'h3C); send_byte(8'h00);
    send_vlq(32'h0FFF_FFFF, 0);
    send_byte(8'h80); send_byte(8'hFF); send_byte(8'hFF);
    send_vlq(0, 3);
    send_byte(8'h9F); send_byte(8'h7F); send_byte(8'h80);
    send_vlq(1, 0);
    send_byte(8'hC5); send_byte(8'h12);
    send_vlq(2, 0);
    send_byte(8'h7F);
    send_vlq(127, 0);
    send_byte(8'hEF); send_byte(8'h00); send_byte(8'h7F);
    send_system(8'hF1);
    send_system(8'hF2);
    send_system(8'hF3);
    send_system(8'hF6);
    send_system(8'hFE);
    send_blob(StatusSysex, 8'h00, 3, 2);
    send_blob(StatusEscape, 8'h00, 0, 0);
    send_blob(StatusMeta, 8'h51, 3, 0);
    send_blob(StatusMeta, 8'h01, 0, 1);
    settle();
    write_limit(2'd2);
    send_channel(8'hB0, 1'b0);
    send_channel(8'hC0, 1'b0);
    send_channel(8'hC0, 1'b1);
    settle();
    write_limit(2'd1);
    send_channel(8'hC3, 1'b0);
    send_channel(8'hC3, 1'b1);
    send_system(8'hF6);
    settle();
    write_limit(2'd0);
    send_system(8'hF6);
    send_channel(8'hA0, 1'b0);
    send_channel(8'hA0, 1'b1);
  endtask

  initial begin
    int         goal;
    bit         end_of_track;
    logic [1:0] plan [5];
    plan         = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    track_byte_i = '0;
    bytes_sent   = 0;
    tx_calm      = 0;
    rx_calm      = 0;
    running_ok   = 1'b0;
    last_running = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed_part();
    foreach (plan[p]) begin
      settle();
      write_limit(plan[p]);
      goal = bytes_sent + 260;
      while (bytes_sent < goal) random_event();
    end

    // the parser halts on either ending, so one is picked per run
    settle();
    end_of_track = $urandom_range(0, 1);
    if (end_of_track) begin
      send_random_delta();
      send_byte(StatusMeta);
      send_byte(MetaEndTrack);
      send_vlq(0, $urandom_range(0, 1));
    end else begin
      send_system(8'hF6);
      send_random_delta();
      send_byte(8'($urandom_range(0, 127)));
    end
    settle();
    repeat (16) send_byte(8'($urandom));
    in_valid_i <= 1'b0;

    for (int i = 0; i < 4000 && pending != 0; i++) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Sent %0d track bytes under limits 0 to 3; %0d results compared.",
             bytes_sent, results_seen);
    $display("Track closed by %s, then idle bytes ignored.",
             end_of_track ? "end-of-track meta" : "data with no running status");
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap(rx_calm);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      @(negedge clk_i);
    end
  end

  initial begin
    #4800000;
    $display("timeout: handshakes stalled");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
